// ----- sv/rpc_pkg.sv -----
// Shared definitions for the response packet checker: framing constants,
// status codes and the byte-wide CRC-16 update. No dependencies.
package rpc_pkg;

	localparam int unsigned MAX_PACKET_BYTES_DEF = 65535;

	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [7:0]  START_BYTE = 8'h01;

	localparam int unsigned HEADER_BYTES       = 14;
	localparam int unsigned HEADER_CRC_LAST    = 11;
	localparam int unsigned DATA_CRC_FEED_FROM = 16;
	localparam int unsigned MIN_DATA_PACKET    = 17;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_SHORT      = 3'd1,
		ST_BAD_START  = 3'd2,
		ST_LEN_MISM   = 3'd3,
		ST_HDR_CRC    = 3'd4,
		ST_BAD_LENGTH = 3'd5,
		ST_DATA_CRC   = 3'd6
	} status_t;

	// Reflected CRC-16 update by one byte, eight shift steps
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- sv/response_packet_checker.sv -----
// Response packet checker top level: input register, framing and CRC checks,
// result register. Depends on rpc_pkg.
//
// The block takes one received response packet a byte at a time on the slave
// stream, with tlast on its final byte, and gives one result per packet on the
// master stream: a status code and the byte count. Byte 0 must be 0x01, bytes
// 2-3 hold the little-endian total length, a reflected CRC-16 (poly 0xA001,
// init 0) over bytes 1..11 must match bytes 12-13, and a packet longer than
// 14 bytes must be at least 17 bytes with the CRC of bytes 14..n-3 matching
// its last two bytes. When several faults hold, the lowest code wins. The
// byte count saturates at MAX_PACKET_BYTES and a saturated packet reports a
// length mismatch. Throughput is one byte per clock unless a final byte
// stalls, as the eight-step CRC update is combinational; a final byte
// passes the input register, then enters the result register once it is
// free. Bytes keep flowing while a result waits at the output; only a final
// byte waits for the result register to free.
// All packet state clears after each final byte; no clearing pass follows reset.
module response_packet_checker
	import rpc_pkg::*;
#(
	parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [2:0] status, [18:3] packet_bytes, [23:19] zero
);

	// Count wide enough to hold the saturation value
	localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKET_BYTES);

	// Input register
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;

	// Packet state
	logic [CNT_W-1:0]  cnt_q;
	logic [15:0]       crc_q;
	logic [15:0]       decl_q;
	logic              start_ok_q;
	logic              hdr_ok_q;
	logic [7:0]        lag0_q;
	logic [7:0]        lag1_q;
	logic              ovf_q;

	// Result register
	status_t           status_s2;
	logic [15:0]       bytes_s2;

	// Next-state values for the byte in the input register
	logic              adv;
	logic              sat;
	logic [CNT_W-1:0]  cnt_n;
	logic [15:0]       crc_n;
	logic [15:0]       decl_n;
	logic              start_ok_n;
	logic              hdr_ok_n;
	logic              ovf_n;
	logic [15:0]       n16;
	logic [15:0]       tail_word;
	status_t           status_n;

	// A plain byte always advances; a final byte needs the result register
	assign adv      = valid_s1 && (!last_s1 || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Framing and CRC update for one byte
	always_comb begin
		sat        = (cnt_q >= CNT_MAX);
		ovf_n      = ovf_q || sat;
		cnt_n      = cnt_q;
		crc_n      = crc_q;
		decl_n     = decl_q;
		start_ok_n = start_ok_q;
		hdr_ok_n   = hdr_ok_q;
		tail_word  = {byte_s1, lag0_q};
		if (!sat) begin
			if (cnt_q == '0) begin
				start_ok_n = (byte_s1 == START_BYTE);
			end else if (cnt_q == CNT_W'(2)) begin
				decl_n[7:0] = byte_s1;
			end else if (cnt_q == CNT_W'(3)) begin
				decl_n[15:8] = byte_s1;
			end
			priority if (cnt_q >= CNT_W'(1) && cnt_q <= CNT_W'(HEADER_CRC_LAST)) begin
				crc_n = crc_feed(crc_q, byte_s1);
			end else if (cnt_q == CNT_W'(HEADER_BYTES - 1)) begin
				// Close the header span and start the data span from zero
				hdr_ok_n = (crc_q == tail_word);
				crc_n    = '0;
			end else if (cnt_q >= CNT_W'(DATA_CRC_FEED_FROM)) begin
				// Data CRC runs two bytes behind, so the trailer never feeds it
				crc_n = crc_feed(crc_q, lag1_q);
			end else begin
				crc_n = crc_q;
			end
			cnt_n = cnt_q + CNT_W'(1);
		end
	end

	// Status for a final byte, lowest code first
	always_comb begin
		n16 = 16'(cnt_n);
		priority if (!ovf_n && n16 < 16'(HEADER_BYTES)) begin
			status_n = ST_SHORT;
		end else if (!start_ok_n) begin
			status_n = ST_BAD_START;
		end else if (ovf_n || decl_n != n16) begin
			status_n = ST_LEN_MISM;
		end else if (!hdr_ok_n) begin
			status_n = ST_HDR_CRC;
		end else if (n16 > 16'(HEADER_BYTES) && n16 < 16'(MIN_DATA_PACKET)) begin
			status_n = ST_BAD_LENGTH;
		end else if (n16 >= 16'(MIN_DATA_PACKET) && crc_n != tail_word) begin
			status_n = ST_DATA_CRC;
		end else begin
			status_n = ST_OK;
		end
	end

	// Hold packet state; clear it after each final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			crc_q      <= '0;
			decl_q     <= '0;
			start_ok_q <= 1'b0;
			hdr_ok_q   <= 1'b0;
			lag0_q     <= '0;
			lag1_q     <= '0;
			ovf_q      <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				cnt_q      <= '0;
				crc_q      <= '0;
				decl_q     <= '0;
				start_ok_q <= 1'b0;
				hdr_ok_q   <= 1'b0;
				lag0_q     <= '0;
				lag1_q     <= '0;
				ovf_q      <= 1'b0;
			end else begin
				cnt_q      <= cnt_n;
				crc_q      <= crc_n;
				decl_q     <= decl_n;
				start_ok_q <= start_ok_n;
				hdr_ok_q   <= hdr_ok_n;
				lag0_q     <= byte_s1;
				lag1_q     <= lag0_q;
				ovf_q      <= ovf_n;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv && last_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			status_s2 <= status_n;
			bytes_s2  <= n16;
		end
	end

	assign m_tdata = {5'b00000, bytes_s2, status_s2};

`ifndef SYNTHESIS
	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("byte count above saturation value");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (cnt_q == '0 && !ovf_q && crc_q == '0))
		else $error("packet state not cleared after final byte");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(adv && last_s1))
		else $error("result raised without a final byte");

	a_ok_length: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status_s2 == ST_OK) |->
		(bytes_s2 == 16'(HEADER_BYTES) || bytes_s2 >= 16'(MIN_DATA_PACKET)))
		else $error("ok status with an invalid packet length");
`endif

endmodule

// ----- dv/packet_verdict_checker.sv -----
// Scoreboard for the response packet checker: a CRC-16/ARC helper package and a
// module that predicts each packet verdict from the accepted bytes and compares it
// with the result stream. Depends on rpc_pkg.
package rpc_tb_pkg;

	import rpc_pkg::*;

	// Reflected CRC-16 update, one data bit at a time from the LSB
	function automatic logic [15:0] crc16_arc_byte(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] c;
		logic        fb;
		c = acc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[i];
			c  = {1'b0, c[15:1]};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

module packet_verdict_checker
	import rpc_pkg::*;
	import rpc_tb_pkg::*;
#(
	parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	output int          mismatches,
	output int          outstanding,
	output int          packets_checked
);

	typedef struct packed {
		status_t     status;
		logic [15:0] packet_bytes;
	} verdict_t;

	verdict_t verdicts_due[$];

	// Model of the framing state
	logic [15:0] seen_count;
	logic [15:0] span_crc;
	logic [15:0] length_field;
	logic        start_good;
	logic        header_good;
	logic [7:0]  prev_byte;
	logic [7:0]  prev2_byte;
	logic        saturated;

	task automatic clear_frame();
		seen_count   = '0;
		span_crc     = '0;
		length_field = '0;
		start_good   = 1'b0;
		header_good  = 1'b0;
		prev_byte    = '0;
		prev2_byte   = '0;
		saturated    = 1'b0;
	endtask

	task automatic absorb_byte(input logic [7:0] b, input logic fin);
		int unsigned idx;
		int unsigned n;
		logic [15:0] tail_word;
		verdict_t    v;
		idx = 32'(seen_count);
		tail_word = {b, prev_byte};
		if (seen_count >= MAX_PACKET_BYTES) begin
			saturated  = 1'b1;
			seen_count = 16'(MAX_PACKET_BYTES);
		end else begin
			if (idx == 0) begin
				start_good = (b == START_BYTE);
			end else if (idx == 2) begin
				length_field[7:0] = b;
			end else if (idx == 3) begin
				length_field[15:8] = b;
			end
			if (idx >= 1 && idx <= HEADER_CRC_LAST) begin
				span_crc = crc16_arc_byte(span_crc, b);
			end else if (idx == HEADER_BYTES - 1) begin
				header_good = (span_crc == tail_word);
				span_crc    = '0;
			end else if (idx >= DATA_CRC_FEED_FROM) begin
				span_crc = crc16_arc_byte(span_crc, prev2_byte);
			end
			seen_count = seen_count + 16'd1;
		end
		if (!fin) begin
			prev2_byte = prev_byte;
			prev_byte  = b;
		end else begin
			n = 32'(seen_count);
			if (!saturated && n < HEADER_BYTES) begin
				v.status = ST_SHORT;
			end else if (!start_good) begin
				v.status = ST_BAD_START;
			end else if (saturated || length_field != n) begin
				v.status = ST_LEN_MISM;
			end else if (!header_good) begin
				v.status = ST_HDR_CRC;
			end else if (n > HEADER_BYTES && n < MIN_DATA_PACKET) begin
				v.status = ST_BAD_LENGTH;
			end else if (n >= MIN_DATA_PACKET && span_crc != tail_word) begin
				v.status = ST_DATA_CRC;
			end else begin
				v.status = ST_OK;
			end
			v.packet_bytes = seen_count;
			verdicts_due.push_back(v);
			clear_frame();
		end
	endtask

	// Signals are read straight after the edge, so they hold their pre-edge values
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			clear_frame();
			verdicts_due.delete();
			mismatches      = 0;
			outstanding     = 0;
			packets_checked = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdicts_due.size() == 0) begin
					$error("result: none expected, got status %0d, packet_bytes %0d",
						m_tdata[2:0], m_tdata[18:3]);
					mismatches++;
				end else begin
					want = verdicts_due.pop_front();
					packets_checked++;
					if (m_tdata[2:0] != want.status) begin
						$error("status: expected %0d, actual %0d", want.status, m_tdata[2:0]);
						mismatches++;
					end
					if (m_tdata[18:3] != want.packet_bytes) begin
						$error("packet_bytes: expected %0d, actual %0d",
							want.packet_bytes, m_tdata[18:3]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				absorb_byte(s_tdata, s_tlast);
			end
			outstanding = verdicts_due.size();
		end
	end

endmodule

// ----- dv/tb_response_packet_checker.sv -----
// Testbench top for the response packet checker: clock, reset, packet stimulus
// and bus idling; prediction and comparison sit in packet_verdict_checker.
// Depends on rpc_pkg, rpc_tb_pkg and the block itself.
module tb_response_packet_checker;

	import rpc_pkg::*;
	import rpc_tb_pkg::*;

	localparam int RANDOM_BYTES = 870;
	// Watchdog time limit, far above the length of the slowest correct run
	localparam int RUN_LIMIT    = 40_000_000;

	typedef enum int {
		PK_GOOD,
		PK_BAD_START,
		PK_BAD_LEN,
		PK_HDR_CRC,
		PK_DATA_CRC,
		PK_NOISE
	} pkt_kind_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] in_byte
	logic        s_tlast  = 1'b0;    // last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;            // [2:0] status, [18:3] packet_bytes, [23:19] zero

	int mismatches;
	int outstanding;
	int packets_checked;

	// Packet under construction, and stimulus bookkeeping
	logic [7:0] pkt[$];
	bit         gaps_on;
	int         random_bytes;
	int         packets_sent;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	response_packet_checker DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	packet_verdict_checker u_verdict_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.packets_checked (packets_checked)
	);

	// Mostly no gap, sometimes a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Lengths favour the minimum header-only packet and short data packets
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			return HEADER_BYTES;
		end else if (r < 95) begin
			return $urandom_range(MIN_DATA_PACKET, 40);
		end
		return $urandom_range(41, 300);
	endfunction

	// Fill pkt with n random bytes, frame them properly, then break one part
	// of the frame according to a faulty kind. Noise keeps the raw random bytes.
	function automatic void build_packet(input int n, input pkt_kind_t kind);
		logic [15:0] crc;
		logic [15:0] n16;
		int          pos;
		pkt.delete();
		for (int i = 0; i < n; i++) begin
			pkt.push_back(8'($urandom_range(0, 255)));
		end
		if (kind == PK_NOISE) begin
			return;
		end
		n16 = n[15:0];
		pkt[0] = START_BYTE;
		if (n >= 4) begin
			pkt[2] = n16[7:0];
			pkt[3] = n16[15:8];
		end
		if (n >= HEADER_BYTES) begin
			crc = '0;
			for (int i = 1; i <= HEADER_CRC_LAST; i++) begin
				crc = crc16_arc_byte(crc, pkt[i]);
			end
			pkt[12] = crc[7:0];
			pkt[13] = crc[15:8];
		end
		if (n >= MIN_DATA_PACKET) begin
			crc = '0;
			for (int i = HEADER_BYTES; i <= n - 3; i++) begin
				crc = crc16_arc_byte(crc, pkt[i]);
			end
			pkt[n-2] = crc[7:0];
			pkt[n-1] = crc[15:8];
		end
		case (kind)
			PK_BAD_START: begin
				pkt[0] = pkt[0] ^ 8'($urandom_range(1, 255));
			end
			PK_BAD_LEN: begin
				if (n >= 4) begin
					pos = $urandom_range(2, 3);
					pkt[pos] = pkt[pos] ^ (8'h01 << $urandom_range(0, 7));
				end
			end
			PK_HDR_CRC: begin
				if (n >= HEADER_BYTES) begin
					pos = $urandom_range(4, 13);
					pkt[pos] = pkt[pos] ^ (8'h01 << $urandom_range(0, 7));
				end
			end
			PK_DATA_CRC: begin
				if (n >= MIN_DATA_PACKET) begin
					pos = $urandom_range(HEADER_BYTES, n - 1);
					pkt[pos] = pkt[pos] ^ (8'h01 << $urandom_range(0, 7));
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Offer each byte of pkt as a request and hold it until accepted. Valid is
	// left high after the last byte so that the next packet can follow directly.
	task automatic send_packet();
		int gap;
		for (int i = 0; i < pkt.size(); i++) begin
			@(negedge clk);
			gap = gaps_on ? pick_gap() : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= pkt[i];
			s_tlast  <= (i == pkt.size() - 1);
			@(posedge clk);
			while (!s_tready) @(posedge clk);
		end
		packets_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// Result side: random ready and stall stretches, each of random length
	initial begin
		int  r;
		int  len;
		logic level;
		forever begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				len   = $urandom_range(1, 8);
				level = 1'b1;
			end else if (r < 90) begin
				len   = $urandom_range(1, 3);
				level = 1'b0;
			end else begin
				len   = $urandom_range(10, 40);
				level = 1'b0;
			end
			repeat (len) begin
				@(negedge clk);
				m_tready <= level;
			end
		end
	end

	initial begin
		int r;
		int n;
		random_bytes = 0;
		packets_sent = 0;
		gaps_on      = 1'b1;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: single-byte extremes, then the key framing lengths
		pkt = '{8'hFF};
		send_packet();
		pkt = '{8'h00};
		send_packet();
		build_packet(HEADER_BYTES - 1, PK_GOOD);
		send_packet();
		build_packet(HEADER_BYTES, PK_GOOD);
		send_packet();
		build_packet(HEADER_BYTES + 1, PK_GOOD);
		send_packet();
		build_packet(MIN_DATA_PACKET - 1, PK_GOOD);
		send_packet();
		build_packet(MIN_DATA_PACKET, PK_GOOD);
		send_packet();

		// Hold off the sender until the block has nothing left to report
		drain_results();

		// Random: well-formed packets, packets of a bad or short length, broken frames and noise
		while (random_bytes < RANDOM_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				build_packet(pick_len(), PK_GOOD);
			end else if (r < 55) begin
				build_packet($urandom_range(HEADER_BYTES + 1, MIN_DATA_PACKET - 1), PK_GOOD);
			end else if (r < 63) begin
				build_packet($urandom_range(1, HEADER_BYTES - 1), PK_GOOD);
			end else if (r < 70) begin
				build_packet(pick_len(), PK_BAD_START);
			end else if (r < 77) begin
				build_packet(pick_len(), PK_BAD_LEN);
			end else if (r < 84) begin
				build_packet(pick_len(), PK_HDR_CRC);
			end else if (r < 92) begin
				n = $urandom_range(MIN_DATA_PACKET, 40);
				build_packet(n, PK_DATA_CRC);
			end else begin
				build_packet($urandom_range(1, 30), PK_NOISE);
			end
			// Some packets go through without any sender idling
			gaps_on = ($urandom_range(0, 3) != 0);
			random_bytes += pkt.size();
			send_packet();
		end

		// Drain, then let the pipeline settle before the verdict
		drain_results();
		repeat (8) @(negedge clk);

		$display("Sent %0d packets, %0d results checked: edge lengths,",
			packets_sent, packets_checked);
		$display("framing and CRC faults, and random packets with idling on both sides.");
		if (mismatches == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog against a hung handshake
	initial begin
		#(RUN_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- response_packet_checker.f -----
sv/rpc_pkg.sv
sv/response_packet_checker.sv
dv/packet_verdict_checker.sv
dv/tb_response_packet_checker.sv
